FILE: rtl/core/swerl_pkg.sv
// Shared types and constants for the sliding-window event rate limiter.
// Depends on nothing; the controller, datapath and top level use it.
`default_nettype none

package swerl_pkg;

    // Field widths of a request and of a stored slot
    localparam int TIME_W  = 31;
    localparam int EVENT_W = 4;
    localparam int COUNT_W = 16;
    localparam int UNIT_W  = 3;
    localparam int SLOT_W  = TIME_W + COUNT_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Window unit codes; any other code means the whole history
    localparam logic [UNIT_W-1:0] UNIT_SECOND = 3'd0;
    localparam logic [UNIT_W-1:0] UNIT_MINUTE = 3'd1;
    localparam logic [UNIT_W-1:0] UNIT_HOUR   = 3'd2;
    localparam logic [UNIT_W-1:0] UNIT_DAY    = 3'd3;

    localparam int SECS_MINUTE = 60;
    localparam int SECS_HOUR   = 60 * 60;
    localparam int SECS_DAY    = 60 * 60 * 24;

    // Distance from the current time back to the window start
    localparam logic [TIME_W-1:0] SPAN_MINUTE = TIME_W'(SECS_MINUTE - 1);
    localparam logic [TIME_W-1:0] SPAN_HOUR   = TIME_W'(SECS_HOUR - 1);
    localparam logic [TIME_W-1:0] SPAN_DAY    = TIME_W'(SECS_DAY - 1);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // latch a new request and clear the accumulators
        logic scan_rd;  // read the next slot of the event
        logic commit;   // decide, update the tables, load the result
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic event_ok;  // the latched event index is in range
        logic scan_last; // the read now issued is the last slot
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/sliding_window_event_rate_limiter.sv
// Sliding-window event rate limiter.
// Request channel: in_valid/in_stall with time_now, event_id, limit_value,
//   window_unit and count_it. A transaction completes when in_valid is high
//   and in_stall is low.
// Result channel: out_valid/out_stall with limited; exactly one result per
//   request, in request order.
// Each request reads all SLOTS_PER_EVENT slots of its event from the slot
//   memory, one per cycle through its single read port, then commits; an
//   event_id beyond NUM_EVENTS skips the scan and answers not limited.
// The next request is accepted only once the last one has committed.
// The result register parts the two sides: a new request is accepted while
//   the last result still waits. If the receiver stalls, the next request
//   holds in its commit step until the result register frees.
// Reset clears event flags and per-event fill counts; slots fill in order,
//   so the slot memory needs no clearing pass and the block is ready at once.
// Depends on swerl_pkg, swerl_ctrl and swerl_dp.
`default_nettype none

module sliding_window_event_rate_limiter
#(
    parameter int NUM_EVENTS      = 16,
    parameter int SLOTS_PER_EVENT = 32
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [swerl_pkg::TIME_W-1:0]    time_now,
    input  wire logic [swerl_pkg::EVENT_W-1:0]   event_id,
    input  wire logic [swerl_pkg::COUNT_W-1:0]   limit_value,
    input  wire logic [swerl_pkg::UNIT_W-1:0]    window_unit,
    input  wire logic                            count_it,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 limited
);

    swerl_pkg::cmd_t    cmd;
    swerl_pkg::status_t status;

    swerl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    swerl_dp
    #(
        .NUM_EVENTS      (NUM_EVENTS),
        .SLOTS_PER_EVENT (SLOTS_PER_EVENT)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .time_now    (time_now),
        .event_id    (event_id),
        .limit_value (limit_value),
        .window_unit (window_unit),
        .count_it    (count_it),
        .limited     (limited)
    );

`ifndef SYNTH
    // One request at a time: busy right after a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while previous one in progress");

    // Never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid && out_stall))
        else $error("result overwritten while stalled");

    // A result appears only after a commit
    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.commit))
        else $error("result without commit");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/swerl_ctrl.sv
// Controller of the rate limiter: request sequencing and the result register.
// Depends on swerl_pkg for the command and status types.
`default_nettype none

module swerl_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    input  wire swerl_pkg::status_t status,
    output swerl_pkg::cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    // The result register can take a new result when empty or being drained
    assign out_free  = !out_valid_reg || !out_stall;

    // Sequence one request: scan its slots (none for an out-of-range event), then commit
    always_comb
    begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.scan_rd = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!status.event_ok)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    if (status.scan_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until the receiver takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/swerl_dp.sv
// Datapath of the rate limiter: request registers, slot memory, window sum,
// match and oldest-slot search, table update. Depends on swerl_pkg.
`default_nettype none

module swerl_dp
#(
    parameter int NUM_EVENTS      = 16,
    parameter int SLOTS_PER_EVENT = 32
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire swerl_pkg::cmd_t                 cmd,
    output swerl_pkg::status_t                   status,
    input  wire logic [swerl_pkg::TIME_W-1:0]    time_now,
    input  wire logic [swerl_pkg::EVENT_W-1:0]   event_id,
    input  wire logic [swerl_pkg::COUNT_W-1:0]   limit_value,
    input  wire logic [swerl_pkg::UNIT_W-1:0]    window_unit,
    input  wire logic                            count_it,
    output logic                                 limited
);

    localparam int TOTAL = NUM_EVENTS * SLOTS_PER_EVENT;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int EW    = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
    localparam int KW    = (SLOTS_PER_EVENT > 1) ? $clog2(SLOTS_PER_EVENT) : 1;
    localparam int FW    = $clog2(SLOTS_PER_EVENT + 1);
    localparam int TW    = swerl_pkg::TIME_W;
    localparam int CW    = swerl_pkg::COUNT_W;

    // Control state: event flags and per-event fill counts
    logic [NUM_EVENTS-1:0] known_reg;
    logic [FW-1:0]         fill_reg [NUM_EVENTS];
    logic                  rd_pend_reg;

    // Request registers
    logic [TW-1:0] ts_reg;
    logic [TW-1:0] start_reg;
    logic [CW-1:0] lim_reg;
    logic          cnt_it_reg;
    logic          ev_ok_reg;
    logic [EW-1:0] ev_reg;
    logic [AW-1:0] base_reg;
    logic [FW-1:0] fill_cur_reg;

    // Scan state and accumulators
    logic [KW-1:0]         k_reg;
    logic [KW-1:0]         rd_k_reg;
    logic [swerl_pkg::SLOT_W-1:0] rd_data_reg;
    logic [CW-1:0]         sum_reg;
    logic                  match_reg;
    logic [KW-1:0]         match_k_reg;
    logic [CW-1:0]         match_cnt_reg;
    logic                  have_old_reg;
    logic [KW-1:0]         old_k_reg;
    logic [TW-1:0]         old_time_reg;
    logic                  limited_reg;

    logic [swerl_pkg::SLOT_W-1:0] mem [TOTAL];

    // Request decode
    logic [31:0]   ev_wide;
    logic [31:0]   base_wide;
    logic          ev_ok;
    logic [EW-1:0] ev_idx;
    logic [TW-1:0] span;
    logic          whole;
    logic [TW-1:0] start;

    assign ev_wide   = 32'(event_id);
    assign ev_ok     = ev_wide < 32'(NUM_EVENTS);
    assign ev_idx    = ev_wide[EW-1:0];
    assign base_wide = ev_wide * 32'(SLOTS_PER_EVENT);

    // Pick the window start from the unit
    always_comb
    begin
        whole = 1'b0;
        span  = '0;
        case (window_unit)
            swerl_pkg::UNIT_SECOND: span = '0;
            swerl_pkg::UNIT_MINUTE: span = swerl_pkg::SPAN_MINUTE;
            swerl_pkg::UNIT_HOUR:   span = swerl_pkg::SPAN_HOUR;
            swerl_pkg::UNIT_DAY:    span = swerl_pkg::SPAN_DAY;
            default:                whole = 1'b1;
        endcase
        // A start below zero takes in every stored time
        if (whole || (time_now < span))
        begin
            start = '0;
        end
        else
        begin
            start = time_now - span;
        end
    end

    // Slot read data
    logic [TW-1:0] rd_time;
    logic [CW-1:0] rd_count;
    logic          slot_live;
    logic [CW:0]   sum_wide;

    assign rd_time   = rd_data_reg[swerl_pkg::SLOT_W-1:CW];
    assign rd_count  = rd_data_reg[CW-1:0];
    assign slot_live = rd_pend_reg && (FW'(rd_k_reg) < fill_cur_reg);
    assign sum_wide  = {1'b0, sum_reg} + {1'b0, rd_count};

    assign status.event_ok  = ev_ok_reg;
    assign status.scan_last = (k_reg == KW'(SLOTS_PER_EVENT - 1));

    // Decision and table update
    logic          limited_now;
    logic          grant;
    logic          do_write;
    logic          has_room;
    logic [KW-1:0] wk;
    logic [CW-1:0] wcount;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;

    assign limited_now = known_reg[ev_reg] && (sum_reg >= lim_reg);
    assign grant       = cmd.commit && ev_ok_reg && !limited_now;
    assign do_write    = grant && cnt_it_reg;
    assign has_room    = fill_cur_reg < FW'(SLOTS_PER_EVENT);
    assign wk          = match_reg ? match_k_reg :
                         (has_room ? fill_cur_reg[KW-1:0] : old_k_reg);
    assign wcount      = !match_reg ? CW'(1) :
                         ((match_cnt_reg == swerl_pkg::COUNT_MAX) ?
                          swerl_pkg::COUNT_MAX : match_cnt_reg + CW'(1));
    assign waddr       = base_reg + AW'(wk);
    assign raddr       = base_reg + AW'(k_reg);
    assign limited     = limited_reg;

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[waddr] <= {ts_reg, wcount};
        end
        if (cmd.scan_rd)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    // Update event flags and fill counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_reg   <= '0;
            rd_pend_reg <= 1'b0;
            for (int i = 0; i < NUM_EVENTS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            rd_pend_reg <= cmd.scan_rd;
            if (grant)
            begin
                known_reg[ev_reg] <= 1'b1;
            end
            if (do_write && !match_reg && has_room)
            begin
                fill_reg[ev_reg] <= fill_cur_reg + FW'(1);
            end
        end
    end

    // Latch the request, step the scan, accumulate
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ts_reg       <= time_now;
            start_reg    <= start;
            lim_reg      <= limit_value;
            cnt_it_reg   <= count_it;
            ev_ok_reg    <= ev_ok;
            ev_reg       <= ev_idx;
            base_reg     <= base_wide[AW-1:0];
            fill_cur_reg <= ev_ok ? fill_reg[ev_idx] : '0;
            k_reg        <= '0;
            sum_reg      <= '0;
            match_reg    <= 1'b0;
            have_old_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_rd)
            begin
                k_reg    <= k_reg + KW'(1);
                rd_k_reg <= k_reg;
            end
            if (slot_live)
            begin
                if (rd_time >= start_reg)
                begin
                    sum_reg <= sum_wide[CW] ? swerl_pkg::COUNT_MAX : sum_wide[CW-1:0];
                end
                if (rd_time == ts_reg)
                begin
                    match_reg     <= 1'b1;
                    match_k_reg   <= rd_k_reg;
                    match_cnt_reg <= rd_count;
                end
                if (!have_old_reg || (rd_time < old_time_reg))
                begin
                    have_old_reg <= 1'b1;
                    old_k_reg    <= rd_k_reg;
                    old_time_reg <= rd_time;
                end
            end
        end
        if (cmd.commit)
        begin
            limited_reg <= ev_ok_reg && limited_now;
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_event_rate_limiter.
// Drives request transactions, predicts each limited flag from its own copy of
// the event and slot tables, and checks results in order. Depends on swerl_pkg.

module tb_top;

    // Field widths, unit codes and window lengths shared with the design
    localparam int TIME_W  = swerl_pkg::TIME_W;
    localparam int EVENT_W = swerl_pkg::EVENT_W;
    localparam int COUNT_W = swerl_pkg::COUNT_W;
    localparam int UNIT_W  = swerl_pkg::UNIT_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = swerl_pkg::COUNT_MAX;
    localparam logic [UNIT_W-1:0]  UNIT_SECOND = swerl_pkg::UNIT_SECOND;
    localparam logic [UNIT_W-1:0]  UNIT_MINUTE = swerl_pkg::UNIT_MINUTE;
    localparam logic [UNIT_W-1:0]  UNIT_HOUR   = swerl_pkg::UNIT_HOUR;
    localparam logic [UNIT_W-1:0]  UNIT_DAY    = swerl_pkg::UNIT_DAY;

    localparam int SECS_MINUTE = swerl_pkg::SECS_MINUTE;
    localparam int SECS_HOUR   = swerl_pkg::SECS_HOUR;
    localparam int SECS_DAY    = swerl_pkg::SECS_DAY;

    localparam int NUM_EV      = 16;
    localparam int SLOTS       = 32;
    localparam int TOTAL_SLOTS = NUM_EV * SLOTS;
    localparam int STUCK_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int MAX_REPORTS = 30;

    // Unit codes outside second..day select the whole history
    localparam logic [UNIT_W-1:0] UNIT_ALL_LO = 3'd4;
    localparam logic [UNIT_W-1:0] UNIT_ALL_HI = 3'd7;
    localparam logic [TIME_W-1:0] TIME_TOP    = '1;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [TIME_W-1:0]   time_now;
    logic [EVENT_W-1:0]  event_id;
    logic [COUNT_W-1:0]  limit_value;
    logic [UNIT_W-1:0]   window_unit;
    logic                count_it;
    logic                out_valid;
    logic                out_stall;
    logic                limited;

    // Predicted table contents
    bit                  ev_known  [NUM_EV];
    bit                  slot_used [TOTAL_SLOTS];
    bit [TIME_W-1:0]     slot_ts   [TOTAL_SLOTS];
    bit [COUNT_W-1:0]    slot_cnt  [TOTAL_SLOTS];

    bit                  pending_limited_q [$];
    int                  errors      = 0;
    int                  n_requests  = 0;
    int                  n_results   = 0;
    int                  n_limited   = 0;
    bit                  tx_idle_on  = 1'b0;
    bit                  rx_idle_on  = 1'b0;
    bit                  hold_long_req = 1'b0;

    sliding_window_event_rate_limiter
    #(
        .NUM_EVENTS      (NUM_EV),
        .SLOTS_PER_EVENT (SLOTS)
    )
    i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .time_now    (time_now),
        .event_id    (event_id),
        .limit_value (limit_value),
        .window_unit (window_unit),
        .count_it    (count_it),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .limited     (limited)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Lowest time still inside the window; may go below zero
    function automatic longint window_floor(bit [TIME_W-1:0] ts, bit [UNIT_W-1:0] unit);
        case (unit)
            UNIT_SECOND: return longint'(ts);
            UNIT_MINUTE: return longint'(ts) - SECS_MINUTE + 1;
            UNIT_HOUR:   return longint'(ts) - SECS_HOUR + 1;
            UNIT_DAY:    return longint'(ts) - SECS_DAY + 1;
            default:     return 0;
        endcase
    endfunction

    // Bump the slot holding ts, else fill a free slot, else evict the oldest
    function automatic void log_hit(int base, bit [TIME_W-1:0] ts);
        int  free_idx;
        int  oldest;
        bit  have_oldest;
        free_idx    = -1;
        oldest      = base;
        have_oldest = 1'b0;
        for (int k = base; k < base + SLOTS; k++)
        begin
            if (slot_used[k])
            begin
                if (slot_ts[k] == ts)
                begin
                    if (slot_cnt[k] != COUNT_MAX)
                        slot_cnt[k]++;
                    return;
                end
                if (!have_oldest || slot_ts[k] < slot_ts[oldest])
                begin
                    oldest      = k;
                    have_oldest = 1'b1;
                end
            end
            else if (free_idx < 0)
            begin
                free_idx = k;
            end
        end
        if (free_idx < 0)
            free_idx = oldest;
        slot_used[free_idx] = 1'b1;
        slot_ts[free_idx]   = ts;
        slot_cnt[free_idx]  = 1;
    endfunction

    // Decide one request and update the predicted tables
    function automatic bit rate_decide(bit [TIME_W-1:0] ts, bit [EVENT_W-1:0] ev,
                                       bit [COUNT_W-1:0] lim, bit [UNIT_W-1:0] unit,
                                       bit cnt_en);
        int          base;
        int unsigned total;
        longint      start;
        bit          hit;
        if (int'(ev) >= NUM_EV)
            return 1'b0;
        base = int'(ev) * SLOTS;
        hit  = 1'b0;
        if (ev_known[ev])
        begin
            start = window_floor(ts, unit);
            total = 0;
            for (int k = base; k < base + SLOTS; k++)
            begin
                if (slot_used[k] && longint'(slot_ts[k]) >= start)
                begin
                    total += slot_cnt[k];
                    if (total > COUNT_MAX)
                        total = COUNT_MAX;
                end
            end
            hit = (total >= lim);
        end
        if (!hit)
        begin
            ev_known[ev] = 1'b1;
            if (cnt_en)
                log_hit(base, ts);
        end
        return hit;
    endfunction

    // Check each result transaction, then predict each request transaction
    always @(posedge clk)
    begin : scoreboard
        bit want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (limited === 1'b1)
                    n_limited++;
                if (pending_limited_q.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual limited=%0b",
                                 $time, limited);
                end
                else
                begin
                    want = pending_limited_q.pop_front();
                    if (limited !== want)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: limited mismatch, expected %0b, actual %0b",
                                     $time, want, limited);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                n_requests++;
                pending_limited_q.push_back(rate_decide(time_now, event_id, limit_value,
                                                        window_unit, count_it));
            end
        end
    end

    // Stall the result side: random short bursts, or one long hold on request
    initial
    begin : receiver
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_long_req)
            begin
                hold_long_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // End the run when no transaction moves for too long
    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                stuck = 0;
            else
                stuck++;
            if (stuck >= STUCK_LIMIT)
                break;
        end
        $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
        $display("[sliding_window_event_rate_limiter] ERROR");
        $finish;
    end

    // Offer one request and hold it until accepted; called at a clock edge
    task automatic send_request(input logic [TIME_W-1:0] ts, input logic [EVENT_W-1:0] ev,
                                input logic [COUNT_W-1:0] lim,
                                input logic [UNIT_W-1:0] unit, input logic cnt_en);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        time_now    <= ts;
        event_id    <= ev;
        limit_value <= lim;
        window_unit <= unit;
        count_it    <= cnt_en;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every predicted result has arrived
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_limited_q.size() != 0);
    endtask

    // Unknown event, zero limit, window edges, future slots, extreme fields
    task automatic test_directed();
        // unknown event passes even with a zero limit, then a zero limit always hits
        send_request(31'd0, 4'd0, 16'd0, UNIT_SECOND, 1'b1);
        send_request(31'd0, 4'd0, 16'd0, UNIT_SECOND, 1'b1);
        send_request(31'd0, 4'd0, 16'd1, UNIT_SECOND, 1'b1);
        send_request(31'd0, 4'd0, 16'd2, UNIT_SECOND, 1'b1);
        // window start below zero on a known event, first with count_it clear, then set
        send_request(31'd5, 4'd0, 16'd3, UNIT_DAY, 1'b0);
        send_request(31'd0, 4'd0, 16'd2, UNIT_MINUTE, 1'b1);
        // a slot stored in the future still counts
        send_request(31'd1000, 4'd1, 16'd1, UNIT_SECOND, 1'b1);
        send_request(31'd10, 4'd1, 16'd1, UNIT_SECOND, 1'b0);
        // minute, hour and day edges around one stored second, then the whole history
        send_request(31'd100, 4'd2, 16'd1, UNIT_SECOND, 1'b1);
        send_request(31'd159, 4'd2, 16'd1, UNIT_MINUTE, 1'b0);
        send_request(31'd160, 4'd2, 16'd1, UNIT_MINUTE, 1'b0);
        send_request(31'd3699, 4'd2, 16'd1, UNIT_HOUR, 1'b0);
        send_request(31'd3700, 4'd2, 16'd1, UNIT_HOUR, 1'b0);
        send_request(31'd86499, 4'd2, 16'd1, UNIT_DAY, 1'b0);
        send_request(31'd86500, 4'd2, 16'd1, UNIT_DAY, 1'b0);
        send_request(31'd86500, 4'd2, 16'd1, UNIT_ALL_LO, 1'b0);
        send_request(31'd90000, 4'd2, 16'd2, UNIT_ALL_HI, 1'b1);
        // top of the time and limit ranges on the last event
        send_request(TIME_TOP, 4'd15, 16'hFFFF, UNIT_ALL_HI, 1'b1);
        send_request(TIME_TOP, 4'd15, 16'hFFFF, UNIT_SECOND, 1'b1);
        send_request(31'd0, 4'd15, 16'd1, UNIT_MINUTE, 1'b1);
        send_request(TIME_TOP, 4'd15, 16'd2, UNIT_SECOND, 1'b1);
    endtask

    // Overfill one event table so the oldest seconds get evicted, then query it
    task automatic test_table_eviction();
        int              ev;
        longint          base_ts;
        logic [UNIT_W-1:0] unit;
        for (int round = 0; round < 2; round++)
        begin
            ev      = $urandom_range(0, NUM_EV - 1);
            base_ts = $urandom_range(0, 1000000);
            for (int i = 0; i < 40; i++)
                send_request(TIME_W'(base_ts + $urandom_range(0, 5000)), EVENT_W'(ev),
                             16'hFFFF, UNIT_W'($urandom_range(0, 7)), 1'b1);
            for (int i = 0; i < 8; i++)
            begin
                unit = UNIT_W'($urandom_range(0, 7));
                send_request(TIME_W'(base_ts + $urandom_range(0, 6000)), EVENT_W'(ev),
                             COUNT_W'($urandom_range(0, 45)), unit, 1'b0);
            end
        end
    endtask

    // Bursts of requests on one event with nearby seconds and small limits
    task automatic test_sequences(input int n_items);
        int                 sent;
        int                 len;
        int                 ev;
        int                 pick;
        longint             t;
        logic [UNIT_W-1:0]  unit;
        logic [COUNT_W-1:0] lim;
        sent = 0;
        while (sent < n_items)
        begin
            ev   = $urandom_range(0, NUM_EV - 1);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                t = $urandom_range(0, 200);
            else if (pick == 1)
                t = longint'(TIME_TOP) - longint'($urandom_range(0, 200));
            else
                t = $urandom_range(0, 32'h7FF0_0000);
            len = $urandom_range(4, 16);
            for (int i = 0; i < len && sent < n_items; i++)
            begin
                // advance time: same second, small steps, window-sized jumps, or back
                pick = $urandom_range(0, 19);
                if (pick < 5)
                    t = t;
                else if (pick < 12)
                    t += $urandom_range(1, 5);
                else if (pick < 15)
                    t += $urandom_range(6, 70);
                else if (pick == 15)
                    t += SECS_HOUR - 1 + $urandom_range(0, 2);
                else if (pick == 16)
                    t += SECS_DAY - 1 + $urandom_range(0, 2);
                else
                    t -= longint'($urandom_range(1, 40));
                if (t < 0)
                    t = 0;
                if (t > longint'(TIME_TOP))
                    t = longint'(TIME_TOP);
                if ($urandom_range(0, 9) < 8)
                    unit = UNIT_W'($urandom_range(UNIT_SECOND, UNIT_DAY));
                else
                    unit = UNIT_W'($urandom_range(UNIT_ALL_LO, UNIT_ALL_HI));
                if ($urandom_range(0, 9) == 0)
                    lim = COUNT_W'($urandom());
                else
                    lim = COUNT_W'($urandom_range(0, 12));
                send_request(TIME_W'(t), EVENT_W'(ev), lim, unit, $urandom_range(0, 9) != 0);
                sent++;
            end
        end
    endtask

    // Fill the block while results are held back, then pause until drained
    task automatic test_backpressure();
        bit saved_tx;
        saved_tx      = tx_idle_on;
        tx_idle_on    = 1'b0;
        hold_long_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_request(TIME_W'(32'd5000 + i), 4'd7, COUNT_W'($urandom_range(0, 8)),
                         UNIT_MINUTE, 1'b1);
        wait_drained();
        tx_idle_on = saved_tx;
    endtask

    // Fully random fields
    task automatic test_noise(input int n_items);
        for (int i = 0; i < n_items; i++)
            send_request(TIME_W'($urandom()), EVENT_W'($urandom_range(0, NUM_EV - 1)),
                         COUNT_W'($urandom()), UNIT_W'($urandom_range(0, 7)),
                         1'(($urandom_range(0, 1))));
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_steady_stream();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_sequences(50);
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        time_now    <= '0;
        event_id    <= '0;
        limit_value <= '0;
        window_unit <= '0;
        count_it    <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_table_eviction();
        test_sequences(300);
        test_backpressure();
        test_noise(80);
        test_steady_stream();

        // drain, then let any stray result show up
        wait_drained();
        repeat (SLOTS + 8) @(posedge clk);

        $display("Covered %0d requests and %0d results (%0d limited): window edges,",
                 n_requests, n_results, n_limited);
        $display("table eviction, long result hold-off, random bursts and noise.");
        if (errors == 0)
            $display("[sliding_window_event_rate_limiter] OK");
        else
            $display("[sliding_window_event_rate_limiter] ERROR");
        $finish;
    end

endmodule
